// ----- hdl/mqsb_pkg.sv -----
// Shared types and constants for the motion queue with backward speed clamp.
package mqsb_pkg;

	localparam int SPEED_W = 16;
	localparam int STEP_W  = 15;
	localparam int OP_W    = 2;

	localparam logic [STEP_W-1:0] STEP_RESET = 15'd50;
	localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sh7FFF;

	typedef enum logic [OP_W-1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DONE    = 2'd1,
		OP_CLAMP   = 2'd2,
		OP_FLUSH   = 2'd3
	} op_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} ram_ctl_t;

endpackage

// ----- hdl/mqsb_ram.sv -----
// Speed store: one write port, one read port, registered read data.
module mqsb_ram #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic                                 clk,
	input  mqsb_pkg::ram_ctl_t                   ctl,
	input  logic [AW-1:0]                        wr_addr,
	input  logic signed [mqsb_pkg::SPEED_W-1:0]  wr_data,
	input  logic [AW-1:0]                        rd_addr,
	output logic signed [mqsb_pkg::SPEED_W-1:0]  rd_data
);

	logic signed [mqsb_pkg::SPEED_W-1:0] mem_q [DEPTH];
	logic signed [mqsb_pkg::SPEED_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read is issued.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/move_queue_speed_backprop.sv -----
// Top level: circular motion queue with per-entry speed and backward speed clamp.
//
//  Channel  Signals                                   Contents
//  s_axis   tvalid tready tdata[15:0] tuser[2:0]      speed; tuser = op, null_move
//  m_axis   tvalid tready tdata[31:0]                 status of the queue after the request
//  cfg      cfg_valid cfg_ready cfg_data[14:0]        slowdown_step
//
// Enqueue, move-done and flush pass through the read and load states before
// the next request is accepted. A clamp first walks the entries it visits,
// at most QUEUE_DEPTH - 1; the walk reads one speed-store entry per cycle.
// Reset clears the indices, the running flag and the controller; the speed
// store is not cleared. A result waiting on m_axis does not stop the next
// request from being taken; it only holds the block before its own result.
module move_queue_speed_backprop #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] speed
	input  logic [2:0]  s_axis_tuser,  // [1:0] op, [2] null_move
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] accepted, [1] running, [4:2] active_slot, [20:5] active_speed,
	// [23:21] queued_count, [24] full_res, [25] empty_res, [31:26] zero
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);
	localparam logic [IW:0]   DEPTH_EXT = (IW+1)'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_READ,
		ST_LOAD
	} state_t;

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] x);
		return (x == LAST_SLOT) ? '0 : x + 1'b1;
	endfunction

	function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] x);
		return (x == '0) ? LAST_SLOT : x - 1'b1;
	endfunction

	state_t                                state_q;
	logic [IW-1:0]                         head_q;
	logic [IW-1:0]                         tail_q;
	logic                                  running_q;
	logic [mqsb_pkg::STEP_W-1:0]           step_q;
	logic                                  accepted_q;
	logic signed [mqsb_pkg::SPEED_W-1:0]   ramp_q;
	logic [IW-1:0]                         walk_q;
	logic                                  out_valid_q;
	logic [31:0]                           out_data_q;

	logic                                  in_fire;
	mqsb_pkg::op_t                         op;
	logic signed [mqsb_pkg::SPEED_W-1:0]   in_speed;
	logic                                  in_null;
	logic [IW-1:0]                         head_next;
	logic [IW-1:0]                         tail_prev;
	logic                                  is_full;

	mqsb_pkg::ram_ctl_t                    ram_ctl;
	logic [IW-1:0]                         wr_addr;
	logic signed [mqsb_pkg::SPEED_W-1:0]   wr_data;
	logic [IW-1:0]                         rd_addr;
	logic signed [mqsb_pkg::SPEED_W-1:0]   rd_data;

	logic signed [mqsb_pkg::SPEED_W:0]     ramp_sum;
	logic signed [mqsb_pkg::SPEED_W-1:0]   ramp_new;
	logic                                  walk_stop;
	logic [IW:0]                           diff;
	logic [IW:0]                           count;
	logic                                  out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign op            = mqsb_pkg::op_t'(s_axis_tuser[1:0]);
	assign in_null       = s_axis_tuser[2];
	assign in_speed      = $signed(s_axis_tdata);
	assign cfg_ready     = 1'b1;

	assign head_next = ring_next(head_q);
	assign tail_prev = ring_prev(tail_q);
	assign is_full   = (head_next == tail_q);

	// Ramp grows by the slowdown step per visited entry and saturates.
	assign ramp_sum = $signed({ramp_q[mqsb_pkg::SPEED_W-1], ramp_q})
	                + $signed({2'b00, step_q});
	assign ramp_new = (ramp_sum > $signed({1'b0, mqsb_pkg::SPEED_MAX}))
	                ? mqsb_pkg::SPEED_MAX : ramp_sum[mqsb_pkg::SPEED_W-1:0];
	// The walk ends at the first entry at or below the ramp. Walking back from
	// head, it reaches the tail entry within QUEUE_DEPTH - 1 entries, so that
	// bound needs no counter of its own.
	assign walk_stop = (rd_data <= ramp_new) || (ring_prev(walk_q) == tail_prev);

	always_comb begin
		ram_ctl = '0;
		wr_addr = head_next;
		wr_data = in_speed;
		rd_addr = tail_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && op == mqsb_pkg::OP_ENQUEUE && !is_full) begin
					ram_ctl.wr_en = 1'b1;
				end
				if (in_fire && op == mqsb_pkg::OP_CLAMP && head_q != tail_prev) begin
					ram_ctl.rd_en = 1'b1;
					rd_addr       = head_q;
				end
			end
			ST_WALK: begin
				if (rd_data > ramp_new) begin
					ram_ctl.wr_en = 1'b1;
					wr_addr       = walk_q;
					wr_data       = ramp_new;
				end
				if (!walk_stop) begin
					ram_ctl.rd_en = 1'b1;
					rd_addr       = ring_prev(walk_q);
				end
			end
			ST_READ: begin
				ram_ctl.rd_en = 1'b1;
				rd_addr       = tail_q;
			end
			default: begin
			end
		endcase
	end

	mqsb_ram #(
		.DEPTH(QUEUE_DEPTH),
		.AW   (IW)
	) u_ram (
		.clk    (clk),
		.ctl    (ram_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign diff     = {1'b0, head_q} - {1'b0, tail_q};
	assign count    = diff[IW] ? diff + DEPTH_EXT : diff;
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			running_q   <= 1'b0;
			step_q      <= mqsb_pkg::STEP_RESET;
			accepted_q  <= 1'b1;
			ramp_q      <= '0;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				step_q <= cfg_data;
			end
			if (state_q == ST_LOAD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						accepted_q <= !(op == mqsb_pkg::OP_ENQUEUE && is_full);
						state_q    <= (op == mqsb_pkg::OP_CLAMP && head_q != tail_prev)
						            ? ST_WALK : ST_READ;
						case (op)
							mqsb_pkg::OP_ENQUEUE: begin
								if (!is_full && !in_null) begin
									head_q <= head_next;
									if (!running_q) begin
										tail_q    <= head_next;
										running_q <= 1'b1;
									end
								end
							end
							mqsb_pkg::OP_DONE: begin
								if (tail_q != head_q) begin
									tail_q    <= ring_next(tail_q);
									running_q <= 1'b1;
								end else begin
									running_q <= 1'b0;
								end
							end
							mqsb_pkg::OP_CLAMP: begin
								ramp_q <= in_speed;
								walk_q <= head_q;
							end
							default: begin
								tail_q    <= head_q;
								running_q <= 1'b0;
							end
						endcase
					end
				end
				ST_WALK: begin
					ramp_q <= ramp_new;
					walk_q <= ring_prev(walk_q);
					if (walk_stop) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						out_data_q  <= {6'd0,
						                (tail_q == head_q) && !running_q,
						                is_full,
						                3'(count),
						                rd_data,
						                3'(tail_q),
						                running_q,
						                accepted_q};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ----- verif/tb_move_queue_speed_backprop.sv -----
// Self-checking testbench for the motion queue with backward speed clamp.
module tb_move_queue_speed_backprop;
	import mqsb_pkg::*;

	localparam int DEPTH = 8;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] speed;
		logic               null_move;
	} motion_req_t;

	// Laid out exactly as m_axis_tdata, so the whole word is compared in one go.
	typedef struct packed {
		logic [5:0]         pad;
		logic               empty;
		logic               full;
		logic [2:0]         count;
		logic signed [15:0] speed;
		logic [2:0]         slot;
		logic               running;
		logic               accepted;
	} queue_status_t;

	typedef struct packed {
		logic [STEP_W-1:0]     step;
		logic [2:0]            head;
		logic [2:0]            tail;
		logic                  running;
		logic [DEPTH-1:0]      written;
		logic [DEPTH-1:0][15:0] store;
	} ring_t;

	typedef enum logic [1:0] {
		CMD_REQUEST,
		CMD_STEP_WRITE,
		CMD_SETTLE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		motion_req_t       req;
		logic [STEP_W-1:0] value;
	} cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [14:0] cfg_data = '0;

	cmd_t          cmd_q[$];
	queue_status_t status_q[$];
	ring_t         plan_ring;
	ring_t         live_ring;
	motion_req_t   cur_req;

	int sent_cnt = 0;
	int seen_cnt = 0;
	int burst_left = 1;
	int gap_left = 0;
	int mismatches = 0;
	int n_enqueue = 0, n_refused = 0, n_done = 0, n_clamp = 0, n_flush = 0, n_step = 0;
	logic [7:0] ready_pat = 8'hFF;
	logic [5:0] pat_tick = '0;

	move_queue_speed_backprop #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Applies one request to a ring and returns the status it leaves behind.
	// stray is set when a speed entry that was never written would be read.
	function automatic queue_status_t next_queue_status(inout ring_t r, input motion_req_t rq,
			output bit stray);
		queue_status_t s;
		logic [2:0] h;
		logic [2:0] i;
		logic [2:0] stop;
		int ramp;
		int n;
		stray = 1'b0;
		s = '0;
		s.accepted = 1'b1;
		case (rq.op)
			OP_ENQUEUE: begin
				h = r.head + 3'd1;
				if (h == r.tail) begin
					s.accepted = 1'b0;
				end else begin
					r.store[h] = rq.speed;
					r.written[h] = 1'b1;
					if (!rq.null_move) begin
						r.head = h;
						if (!r.running) begin
							r.tail = h;
							r.running = 1'b1;
						end
					end
				end
			end
			OP_DONE: begin
				if (r.tail != r.head) begin
					r.tail = r.tail + 3'd1;
					r.running = 1'b1;
				end else begin
					r.running = 1'b0;
				end
			end
			OP_CLAMP: begin
				ramp = int'(rq.speed);
				i = r.head;
				stop = r.tail - 3'd1;
				for (n = 0; n < DEPTH && i != stop; n++) begin
					ramp = ramp + int'(r.step);
					if (ramp > 32767)
						ramp = 32767;
					if (!r.written[i])
						stray = 1'b1;
					if (int'($signed(r.store[i])) <= ramp)
						break;
					r.store[i] = ramp[15:0];
					i = i - 3'd1;
				end
			end
			default: begin
				r.tail = r.head;
				r.running = 1'b0;
			end
		endcase
		h = r.head + 3'd1;
		if (!r.written[r.tail])
			stray = 1'b1;
		s.running = r.running;
		s.slot = r.tail;
		s.speed = r.store[r.tail];
		s.count = r.head - r.tail;
		s.full = (h == r.tail);
		s.empty = (r.tail == r.head) && !r.running;
		return s;
	endfunction

	function automatic motion_req_t make_req(op_t op, int speed, bit null_move);
		motion_req_t rq;
		rq.op = op;
		rq.speed = speed[15:0];
		rq.null_move = null_move;
		return rq;
	endfunction

	function automatic motion_req_t random_request(bit fill_heavy);
		int r;
		int spd;
		op_t op;
		r = $urandom_range(0, 99);
		if (fill_heavy)
			op = (r < 55) ? OP_ENQUEUE : (r < 80) ? OP_DONE : (r < 95) ? OP_CLAMP : OP_FLUSH;
		else
			op = (r < 35) ? OP_ENQUEUE : (r < 70) ? OP_DONE : (r < 93) ? OP_CLAMP : OP_FLUSH;
		case ($urandom_range(0, 4))
			0: spd = $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: spd = 32767;
					1: spd = -32768;
					2: spd = 0;
					default: spd = -1;
				endcase
			end
			2: spd = int'($urandom_range(0, 400)) - 200;
			3: spd = $urandom_range(15000, 32767);
			default: spd = $urandom_range(0, 3000);
		endcase
		return make_req(op, spd, $urandom_range(0, 9) == 0);
	endfunction

	// Queues a request, replacing it by a plain enqueue if it would read a
	// speed entry that nothing has written yet.
	task automatic plan_request(motion_req_t rq);
		ring_t trial;
		bit stray;
		cmd_t c;
		trial = plan_ring;
		void'(next_queue_status(trial, rq, stray));
		if (stray) begin
			rq.op = OP_ENQUEUE;
			rq.null_move = 1'b0;
			trial = plan_ring;
			void'(next_queue_status(trial, rq, stray));
		end
		plan_ring = trial;
		c = '0;
		c.kind = CMD_REQUEST;
		c.req = rq;
		cmd_q.push_back(c);
	endtask

	task automatic plan_step_write(int value);
		cmd_t c;
		c = '0;
		c.kind = CMD_STEP_WRITE;
		c.value = value[STEP_W-1:0];
		plan_ring.step = c.value;
		cmd_q.push_back(c);
	endtask

	task automatic plan_settle();
		cmd_t c;
		c = '0;
		c.kind = CMD_SETTLE;
		cmd_q.push_back(c);
	endtask

	function automatic string show_status(queue_status_t s);
		return $sformatf("acc=%0d run=%0d slot=%0d speed=%0d count=%0d full=%0d empty=%0d pad=%0h",
			s.accepted, s.running, s.slot, s.speed, s.count, s.full, s.empty, s.pad);
	endfunction

	// Request and configuration driver.
	always @(posedge clk or negedge arst_n) begin : driver
		logic v_n;
		logic c_n;
		int in_flight;
		bit stray;
		cmd_t c;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			cfg_valid <= 1'b0;
			cfg_data <= '0;
		end else begin
			v_n = s_axis_tvalid;
			c_n = cfg_valid;
			in_flight = sent_cnt - seen_cnt;
			if (s_axis_tvalid && s_axis_tready) begin
				status_q.push_back(next_queue_status(live_ring, cur_req, stray));
				case (cur_req.op)
					OP_ENQUEUE: begin
						n_enqueue++;
						if (!status_q[$].accepted)
							n_refused++;
					end
					OP_DONE:  n_done++;
					OP_CLAMP: n_clamp++;
					default:  n_flush++;
				endcase
				sent_cnt <= sent_cnt + 1;
				in_flight++;
				v_n = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				live_ring.step = cfg_data;
				n_step++;
				c_n = 1'b0;
			end
			if (!v_n && !c_n) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end else if (cmd_q.size() != 0) begin
					c = cmd_q[0];
					case (c.kind)
						CMD_REQUEST: begin
							void'(cmd_q.pop_front());
							cur_req = c.req;
							s_axis_tdata <= c.req.speed;
							s_axis_tuser <= {c.req.null_move, c.req.op};
							v_n = 1'b1;
							if (burst_left <= 1) begin
								burst_left <= $urandom_range(1, 24);
								gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
							end else begin
								burst_left <= burst_left - 1;
							end
						end
						CMD_STEP_WRITE: begin
							// The block must be idle: every result already taken.
							if (in_flight == 0) begin
								void'(cmd_q.pop_front());
								cfg_data <= c.value;
								c_n = 1'b1;
							end
						end
						default: begin
							if (in_flight == 0)
								void'(cmd_q.pop_front());
						end
					endcase
				end
			end
			s_axis_tvalid <= v_n;
			cfg_valid <= c_n;
		end
	end

	// Status monitor with a changing stall pattern on m_axis_tready.
	always @(posedge clk or negedge arst_n) begin : monitor
		queue_status_t got;
		queue_status_t want;
		logic [7:0] pat;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_cnt <= seen_cnt + 1;
				got = m_axis_tdata;
				if (status_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected status: %s", show_status(got));
				end else begin
					want = status_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Status mismatch\n  expected %s\n  actual   %s",
								show_status(want), show_status(got));
					end
				end
			end
			pat = ready_pat;
			if (pat_tick == 6'd63) begin
				case ($urandom_range(0, 3))
					0: pat = 8'hFF;
					1: pat = 8'($urandom) | 8'h01;
					2: pat = 8'h01;
					default: pat = 8'($urandom) | 8'h81;
				endcase
			end
			ready_pat <= pat;
			pat_tick <= pat_tick + 6'd1;
			m_axis_tready <= pat[pat_tick[2:0]];
		end
	end

	initial begin
		int ph;
		int k;
		plan_ring = '0;
		plan_ring.step = STEP_RESET;
		live_ring = plan_ring;

		// Fill to full with extreme speeds, including a null move.
		plan_request(make_req(OP_ENQUEUE, 32767, 1'b0));
		plan_request(make_req(OP_ENQUEUE, -32768, 1'b1));
		plan_request(make_req(OP_ENQUEUE, 1000, 1'b0));
		plan_request(make_req(OP_ENQUEUE, -1, 1'b0));
		plan_request(make_req(OP_ENQUEUE, 0, 1'b0));
		plan_request(make_req(OP_ENQUEUE, 20000, 1'b0));
		plan_request(make_req(OP_ENQUEUE, 12345, 1'b0));
		plan_request(make_req(OP_ENQUEUE, 30000, 1'b0));
		plan_request(make_req(OP_ENQUEUE, 100, 1'b0));
		plan_request(make_req(OP_ENQUEUE, 5, 1'b0));
		plan_request(make_req(OP_CLAMP, -32768, 1'b0));
		plan_request(make_req(OP_CLAMP, 32767, 1'b0));
		plan_request(make_req(OP_CLAMP, 0, 1'b0));
		plan_request(make_req(OP_DONE, 0, 1'b0));
		plan_request(make_req(OP_DONE, 0, 1'b0));
		plan_request(make_req(OP_CLAMP, 500, 1'b0));
		plan_request(make_req(OP_FLUSH, -1, 1'b1));
		// Move done and clamp while idle, then a null move while idle.
		plan_request(make_req(OP_DONE, 0, 1'b0));
		plan_request(make_req(OP_CLAMP, -100, 1'b0));
		plan_request(make_req(OP_ENQUEUE, 777, 1'b1));
		plan_request(make_req(OP_ENQUEUE, -5000, 1'b0));

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: plan_step_write(32767);
				1: plan_step_write(0);
				2: plan_step_write(1);
				3: plan_step_write(int'(STEP_RESET));
				4: plan_step_write(16384);
				5: plan_step_write($urandom_range(1, 300));
				default: plan_step_write($urandom_range(0, 32767));
			endcase
			for (k = 0; k < 245; k++) begin
				plan_request(random_request(ph[0]));
				if ($urandom_range(0, 99) == 0)
					plan_settle();
			end
		end
		plan_step_write(int'(STEP_RESET));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(posedge clk);
		while (cmd_q.size() != 0 || s_axis_tvalid || cfg_valid || sent_cnt != seen_cnt);
		repeat (20) @(posedge clk);
		if (status_q.size() != 0) begin
			mismatches += status_q.size();
			$display("%0d expected statuses never arrived", status_q.size());
		end
		$display("Covered %0d enqueues (%0d refused when full), %0d move-done, %0d clamps,",
			n_enqueue, n_refused, n_done, n_clamp);
		$display("%0d flushes and %0d slowdown step writes; %0d mismatches.",
			n_flush, n_step, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("Run did not finish in time");
		$display("TB_ERROR");
		$finish;
	end

endmodule
